// ----- rtl/datagram_frame_validator_assert.svh -----
// Assertion macros for the datagram frame validator checker.
`ifndef DATAGRAM_FRAME_VALIDATOR_ASSERT_SVH
`define DATAGRAM_FRAME_VALIDATOR_ASSERT_SVH

// same-cycle implication, checked while out of reset
`define DFV_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked while out of reset
`define DFV_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/dfv_pkg.sv -----
// Package for the datagram frame validator: constants, types and the CRC step.
package dfv_pkg;

  localparam int MAX_TGT      = 16;
  localparam int MAX_DATAGRAM = 4096;

  localparam int CNT_W = $clog2(MAX_DATAGRAM);
  localparam int LEN_W = $clog2(MAX_DATAGRAM + 1);
  localparam int EXP_W = $clog2(19 + 27 * 255 + 1);
  localparam int CMP_W = (LEN_W > EXP_W) ? LEN_W : EXP_W;

  localparam logic [15:0] MAGIC_OLD = 16'h55AA;
  localparam logic [15:0] MAGIC_NEW = 16'h55AB;
  localparam logic [15:0] CRC_POLY  = 16'h1021;
  localparam logic [15:0] CRC_INIT  = 16'hFFFF;

  localparam logic [CNT_W-1:0] IDX_LAST = CNT_W'(MAX_DATAGRAM - 1);
  localparam logic [CNT_W-1:0] IDX_VER  = CNT_W'(2);
  localparam logic [CNT_W-1:0] IDX_CNT  = CNT_W'(16);

  localparam logic [1:0] PROTO_NONE   = 2'd0;
  localparam logic [1:0] PROTO_LEGACY = 2'd1;
  localparam logic [1:0] PROTO_NEW    = 2'd2;

  typedef enum logic [2:0] {
    ST_OK               = 3'd0,
    ST_BAD_MAGIC        = 3'd1,
    ST_LEGACY_OFF       = 3'd2,
    ST_LENGTH           = 3'd3,
    ST_VER_CNT          = 3'd4,
    ST_CRC              = 3'd5,
    ST_STALE            = 3'd6,
    ST_LEGACY_AFTER_NEW = 3'd7
  } status_t;

  typedef struct packed {
    logic [CNT_W-1:0] idx;
    logic [15:0]      crc;
    logic [15:0]      magic;
    logic [7:0]       version;
    logic [7:0]       count;
    logic [31:0]      seq;
    logic [15:0]      rx_crc;
  } frame_view_t;

  typedef struct packed {
    logic        frame_ok;
    status_t     status;
    logic [1:0]  version;
    logic [31:0] seq;
    logic [4:0]  count;
  } result_t;

  function automatic logic [15:0] crc_fold(input logic [15:0] crc, input logic [7:0] data);
    logic [15:0] c;
    c = crc ^ {data, 8'h00};
    for (int b = 0; b < 8; b++) begin
      if (c[15]) begin
        c = {c[14:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

  function automatic logic seq_newer(input logic [31:0] seq, input logic [31:0] last);
    logic [31:0] diff;
    diff = seq - last;
    return (diff != 32'd0) && !diff[31];
  endfunction

endpackage

// ----- rtl/dfv_frame.sv -----
// Per-datagram header capture, byte counter and running CRC.
module dfv_frame (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                accept,
  input  logic                last,
  input  logic [7:0]          data_byte,
  output dfv_pkg::frame_view_t view
);

  logic [dfv_pkg::CNT_W-1:0] byte_count_r, byte_count_nxt;
  logic [15:0]               crc_acc_r, crc_acc_nxt;
  logic [7:0]                byte_delay_r, byte_delay_prev_r;
  logic [15:0]               magic_r, magic_nxt;
  logic [7:0]                version_r, version_nxt;
  logic [7:0]                count_r, count_nxt;
  logic [31:0]               seq_r, seq_nxt;
  logic [dfv_pkg::CNT_W-1:0] base;

  always_comb begin
    crc_acc_nxt = (byte_count_r >= dfv_pkg::CNT_W'(2))
                ? dfv_pkg::crc_fold(crc_acc_r, byte_delay_prev_r) : crc_acc_r;
    magic_nxt = magic_r;
    if (byte_count_r == '0) begin
      magic_nxt[7:0] = data_byte;
    end else if (byte_count_r == dfv_pkg::CNT_W'(1)) begin
      magic_nxt[15:8] = data_byte;
    end
    version_nxt = (byte_count_r == dfv_pkg::IDX_VER) ? data_byte : version_r;
    count_nxt   = (byte_count_r == dfv_pkg::IDX_CNT) ? data_byte : count_r;
    base = (magic_nxt == dfv_pkg::MAGIC_OLD) ? dfv_pkg::CNT_W'(2) : dfv_pkg::CNT_W'(4);
    seq_nxt = seq_r;
    for (int k = 0; k < 4; k++) begin
      if (byte_count_r == base + dfv_pkg::CNT_W'(k)) begin
        seq_nxt[8*k +: 8] = seq_r[8*k +: 8] | data_byte;
      end
    end
    byte_count_nxt = (byte_count_r < dfv_pkg::IDX_LAST)
                   ? byte_count_r + dfv_pkg::CNT_W'(1) : byte_count_r;

    view.idx     = byte_count_r;
    view.crc     = crc_acc_nxt;
    view.magic   = magic_nxt;
    view.version = version_nxt;
    view.count   = count_nxt;
    view.seq     = seq_nxt;
    view.rx_crc  = {data_byte, byte_delay_r};
  end

  always_ff @(posedge clk) begin
    if (!rst_n || (accept && last)) begin
      byte_count_r      <= '0;
      crc_acc_r         <= dfv_pkg::CRC_INIT;
      byte_delay_r      <= '0;
      byte_delay_prev_r <= '0;
      magic_r           <= '0;
      version_r         <= '0;
      count_r           <= '0;
      seq_r             <= '0;
    end else if (accept) begin
      byte_count_r      <= byte_count_nxt;
      crc_acc_r         <= crc_acc_nxt;
      byte_delay_r      <= data_byte;
      byte_delay_prev_r <= byte_delay_r;
      magic_r           <= magic_nxt;
      version_r         <= version_nxt;
      count_r           <= count_nxt;
      seq_r             <= seq_nxt;
    end
  end

endmodule

// ----- rtl/dfv_check.sv -----
// Frame checks at the final byte and per-format sequence tracking.
module dfv_check (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 commit,
  input  logic                 legacy_enable,
  input  dfv_pkg::frame_view_t view,
  output dfv_pkg::result_t     result
);

  logic [31:0] newest_new_seq_r, newest_old_seq_r;
  logic        new_seq_valid_r, old_seq_valid_r, new_format_seen_r;

  logic [dfv_pkg::LEN_W-1:0] len;
  logic [dfv_pkg::CMP_W-1:0] len_ext, exp_len;
  dfv_pkg::status_t          status;
  logic [1:0]                ver;
  logic [4:0]                cnt;

  always_comb begin
    len     = dfv_pkg::LEN_W'(view.idx) + dfv_pkg::LEN_W'(1);
    len_ext = dfv_pkg::CMP_W'(len);
    exp_len = dfv_pkg::CMP_W'(19) + dfv_pkg::CMP_W'(27) * dfv_pkg::CMP_W'(view.count);
    status  = dfv_pkg::ST_OK;
    ver     = dfv_pkg::PROTO_NONE;
    cnt     = '0;
    if (view.idx == '0 ||
        (view.magic != dfv_pkg::MAGIC_NEW && view.magic != dfv_pkg::MAGIC_OLD)) begin
      status = dfv_pkg::ST_BAD_MAGIC;
    end else if (view.magic == dfv_pkg::MAGIC_NEW) begin
      ver = dfv_pkg::PROTO_NEW;
      if (len < dfv_pkg::LEN_W'(19)) begin
        status = dfv_pkg::ST_LENGTH;
      end else if (view.version != 8'd2 || view.count > 8'(dfv_pkg::MAX_TGT)) begin
        status = dfv_pkg::ST_VER_CNT;
      end else if (len_ext != exp_len) begin
        status = dfv_pkg::ST_LENGTH;
      end else if (view.crc != view.rx_crc) begin
        status = dfv_pkg::ST_CRC;
      end else if (new_seq_valid_r && !dfv_pkg::seq_newer(view.seq, newest_new_seq_r)) begin
        status = dfv_pkg::ST_STALE;
      end else begin
        cnt = (view.count > 8'd31) ? 5'd31 : view.count[4:0];
      end
    end else begin
      ver = dfv_pkg::PROTO_LEGACY;
      if (!legacy_enable) begin
        status = dfv_pkg::ST_LEGACY_OFF;
      end else if (len != dfv_pkg::LEN_W'(29)) begin
        status = dfv_pkg::ST_LENGTH;
      end else if (view.crc != view.rx_crc) begin
        status = dfv_pkg::ST_CRC;
      end else if (new_format_seen_r) begin
        status = dfv_pkg::ST_LEGACY_AFTER_NEW;
      end else if (old_seq_valid_r && !dfv_pkg::seq_newer(view.seq, newest_old_seq_r)) begin
        status = dfv_pkg::ST_STALE;
      end else begin
        cnt = 5'd1;
      end
    end
    result.frame_ok = (status == dfv_pkg::ST_OK);
    result.status   = status;
    result.version  = ver;
    result.seq      = view.seq;
    result.count    = cnt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      newest_new_seq_r  <= '0;
      newest_old_seq_r  <= '0;
      new_seq_valid_r   <= 1'b0;
      old_seq_valid_r   <= 1'b0;
      new_format_seen_r <= 1'b0;
    end else if (commit && status == dfv_pkg::ST_OK) begin
      if (ver == dfv_pkg::PROTO_NEW) begin
        newest_new_seq_r  <= view.seq;
        new_seq_valid_r   <= 1'b1;
        new_format_seen_r <= 1'b1;
      end else begin
        newest_old_seq_r <= view.seq;
        old_seq_valid_r  <= 1'b1;
      end
    end
  end

endmodule

// ----- rtl/datagram_frame_validator.sv -----
// Datagram frame validator top level: handshakes, config register, result register.
//
//  channel  direction  handshake          transfer
//  in_      in         in_valid/in_stall  one datagram byte and end flag
//  out_     out        out_valid/out_stall one frame verdict per datagram
//  cfg_     in         cfg_valid/cfg_ready legacy_enable bit
//
// One byte per cycle while in_stall is low; the verdict for a datagram appears in the
// cycle after its final byte is transferred, from the result register.
// The per-byte CRC step and the final-byte checks are combinational, in front of the result register.
// Reset is synchronous; it clears frame state, sequence history and the config bit.
// Input stalls only while a verdict is held by out_stall.
module datagram_frame_validator (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_data_byte,
  input  logic        in_end_of_datagram,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_frame_ok,
  output logic [2:0]  out_status,
  output logic [1:0]  out_protocol_version,
  output logic [31:0] out_frame_seq,
  output logic [4:0]  out_target_count,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_legacy_enable
);

  logic                 legacy_enable_r;
  logic                 out_valid_r, out_valid_nxt;
  dfv_pkg::result_t     result, result_r;
  dfv_pkg::frame_view_t view;
  logic                 accept, acc_last;

  assign in_stall  = out_valid_r && out_stall;
  assign accept    = in_valid && !in_stall;
  assign acc_last  = accept && in_end_of_datagram;
  assign cfg_ready = 1'b1;

  dfv_frame u_frame (
    .clk       (clk),
    .rst_n     (rst_n),
    .accept    (accept),
    .last      (in_end_of_datagram),
    .data_byte (in_data_byte),
    .view      (view)
  );

  dfv_check u_check (
    .clk           (clk),
    .rst_n         (rst_n),
    .commit        (acc_last),
    .legacy_enable (legacy_enable_r),
    .view          (view),
    .result        (result)
  );

  always_comb begin
    if (acc_last) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r     <= 1'b0;
      legacy_enable_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        legacy_enable_r <= cfg_legacy_enable;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (acc_last) begin
      result_r <= result;
    end
  end

  assign out_valid            = out_valid_r;
  assign out_frame_ok         = result_r.frame_ok;
  assign out_status           = result_r.status;
  assign out_protocol_version = result_r.version;
  assign out_frame_seq        = result_r.seq;
  assign out_target_count     = result_r.count;

endmodule

// ----- rtl/dfv_checker.sv -----
// Port-level assertion checker for the datagram frame validator, with its bind.
`include "datagram_frame_validator_assert.svh"

module dfv_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_stall,
  input logic        in_end_of_datagram,
  input logic        out_valid,
  input logic        out_stall,
  input logic        out_frame_ok,
  input logic [2:0]  out_status,
  input logic [1:0]  out_protocol_version,
  input logic [31:0] out_frame_seq,
  input logic [4:0]  out_target_count
);

  `DFV_ASSERT_NOW(a_ok_matches_status, out_valid,
    out_frame_ok == (out_status == dfv_pkg::ST_OK), "frame_ok disagrees with status")

  `DFV_ASSERT_NOW(a_refused_no_targets, out_valid && !out_frame_ok,
    out_target_count == 5'd0, "refused frame reports targets")

  `DFV_ASSERT_NOW(a_bad_magic_no_version, out_valid && out_status == dfv_pkg::ST_BAD_MAGIC,
    out_protocol_version == dfv_pkg::PROTO_NONE, "bad magic with a protocol version")

  `DFV_ASSERT_NEXT(a_verdict_follows_last, in_valid && !in_stall && in_end_of_datagram,
    out_valid, "no verdict after final byte transfer")

  `DFV_ASSERT_NEXT(a_stalled_result_holds, out_valid && out_stall,
    out_valid && $stable(out_frame_seq) && $stable(out_status), "stalled result changed")

endmodule

bind datagram_frame_validator dfv_checker u_dfv_checker (.*);
